// ===== hdl/rwp_pkg.sv =====
`default_nettype none

package rwp_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned WordW   = 32;
  localparam int unsigned KindW   = 2;
  localparam int unsigned StatusW = 3;

  // Item kinds on the result channel
  localparam logic [KindW-1:0] ItemPcm16   = 2'd0;
  localparam logic [KindW-1:0] ItemFloat32 = 2'd1;
  localparam logic [KindW-1:0] ItemStatus  = 2'd2;

  // Final status codes
  localparam logic [StatusW-1:0] StatusOk        = 3'd0;
  localparam logic [StatusW-1:0] StatusNotRiff   = 3'd1;
  localparam logic [StatusW-1:0] StatusNoData    = 3'd2;
  localparam logic [StatusW-1:0] StatusNotMono   = 3'd3;
  localparam logic [StatusW-1:0] StatusBadFormat = 3'd4;
  localparam logic [StatusW-1:0] StatusWrongRate = 3'd5;

  // Parser position inside the chunk stream
  localparam logic [1:0] ChunkHead = 2'd0;
  localparam logic [1:0] ChunkFmt  = 2'd1;
  localparam logic [1:0] ChunkData = 2'd2;
  localparam logic [1:0] ChunkSkip = 2'd3;

  localparam logic [3:0]  HeaderLen  = 4'd12;
  localparam logic [4:0]  FmtLen     = 5'd16;
  localparam logic [31:0] FmtMinLen  = 32'd16;
  localparam logic [31:0] TagFmt     = 32'h2074_6D66;
  localparam logic [31:0] TagData    = 32'h6174_6164;
  localparam logic [31:0] RateReset  = 32'd16000;
  localparam logic [15:0] FormatPcm  = 16'd1;
  localparam logic [15:0] FormatFlt  = 16'd3;
  localparam logic [15:0] BitsPcm    = 16'd16;
  localparam logic [15:0] BitsFlt    = 16'd32;

  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = 2;
  localparam int unsigned QCntW  = 3;

  typedef struct packed {
    logic [KindW-1:0]   item_kind;
    logic [WordW-1:0]   sample_word;
    logic [StatusW-1:0] status_code;
    logic               is_last;
  } item_t;

  // Expected "RIFF....WAVE" bytes; the size field bytes are don't-care
  function automatic logic [ByteW-1:0] head_byte(input logic [3:0] idx);
    logic [ByteW-1:0] r;
    unique case (idx)
      4'd0:    r = 8'h52;
      4'd1:    r = 8'h49;
      4'd2:    r = 8'h46;
      4'd3:    r = 8'h46;
      4'd8:    r = 8'h57;
      4'd9:    r = 8'h41;
      4'd10:   r = 8'h56;
      4'd11:   r = 8'h45;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/rwp_cfg_if.sv =====
`default_nettype none

interface rwp_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [rwp_pkg::WordW-1:0]  wanted_rate;

  modport source (output valid, output wanted_rate, input ready);
  modport sink   (input valid, input wanted_rate, output ready);
endinterface

`default_nettype wire

// ===== hdl/rwp_byte_if.sv =====
`default_nettype none

interface rwp_byte_if;
  logic                       valid;
  logic                       ready;
  logic [rwp_pkg::ByteW-1:0]  file_byte;
  logic                       end_of_file;

  modport source (output valid, output file_byte, output end_of_file, input ready);
  modport sink   (input valid, input file_byte, input end_of_file, output ready);
endinterface

`default_nettype wire

// ===== hdl/rwp_item_if.sv =====
`default_nettype none

interface rwp_item_if;
  logic                         valid;
  logic                         ready;
  logic [rwp_pkg::KindW-1:0]    item_kind;
  logic [rwp_pkg::WordW-1:0]    sample_word;
  logic [rwp_pkg::StatusW-1:0]  status_code;
  logic                         is_last;

  modport source (output valid, output item_kind, output sample_word, output status_code,
                  output is_last, input ready);
  modport sink   (input valid, input item_kind, input sample_word, input status_code,
                  input is_last, output ready);
endinterface

`default_nettype wire

// ===== hdl/riff_wav_stream_parser.sv =====
// RIFF/WAVE byte-stream parser.
// byte_i carries the file one byte per beat, with end_of_file set on the last byte.
// item_o carries results: pcm16 samples (sign-extended), float32 sample bits, and one
// final status beat (is_last set) after the last byte of each file.
// The user must write wanted_rate on cfg_i only while the parser is idle; the parser
// itself does not enforce this. cfg_i is always ready. Throughput: one byte per cycle
// while the result queue has room. Each byte updates the parse state in the cycle it
// is accepted and pushes zero, one or two results into a registered 4-entry queue.
// byte_i.ready is high while the queue has room for two results, so a stalled
// receiver backs up into the byte channel after at most four results are held.
// Reset: wanted_rate returns to 16000, all parse state is cleared and the queue is
// emptied. After the byte marked end_of_file the parse state clears again and the
// next byte starts a new file; wanted_rate keeps its value.
`default_nettype none

module riff_wav_stream_parser (
  input  logic            clk_i,
  input  logic            rst_ni,
  rwp_cfg_if.sink         cfg_i,
  rwp_byte_if.sink        byte_i,
  rwp_item_if.source      item_o
);

  function automatic logic [31:0] set_byte(input logic [31:0] v, input logic [1:0] pos,
                                           input logic [7:0] b);
    logic [31:0] r;
    r = v;
    unique case (pos)
      2'd0: r[7:0]   = b;
      2'd1: r[15:8]  = b;
      2'd2: r[23:16] = b;
      2'd3: r[31:24] = b;
      default: r = v;
    endcase
    return r;
  endfunction

  logic [31:0] wanted_rate_q;

  logic [3:0]  header_count_q, header_count_d;
  logic        header_good_q, header_good_d;
  logic [2:0]  chunk_head_count_q, chunk_head_count_d;
  logic [31:0] chunk_tag_q, chunk_tag_d;
  logic [31:0] chunk_length_q, chunk_length_d;
  logic [31:0] body_left_q, body_left_d;
  logic [4:0]  body_offset_q, body_offset_d;
  logic [1:0]  chunk_kind_q, chunk_kind_d;
  logic        pad_pending_q, pad_pending_d;
  logic [15:0] stream_format_q, stream_format_d;
  logic [15:0] stream_channels_q, stream_channels_d;
  logic [31:0] stream_rate_q, stream_rate_d;
  logic [15:0] stream_bits_q, stream_bits_d;
  logic        data_seen_q, data_seen_d;
  logic [31:0] sample_gather_q, sample_gather_d;
  logic [1:0]  sample_byte_count_q, sample_byte_count_d;
  logic        fmt_valid_q, fmt_valid_d;

  logic               in_acc;
  logic [7:0]         b;
  logic               take_pcm16, take_float32;
  logic               sample_emit;
  rwp_pkg::item_t     sample_item, status_item;
  logic [2:0]         need;
  logic [2:0]         cnt_inc;
  logic [31:0]        gather_new;
  logic               end_pcm16, end_float32;

  rwp_pkg::item_t             queue_q [rwp_pkg::QDepth];
  logic [rwp_pkg::QPtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [rwp_pkg::QCntW-1:0]  count_q, count_d;
  logic                       out_acc;
  logic [1:0]                 n_push;
  rwp_pkg::item_t             first_item;

  assign in_acc       = byte_i.valid && byte_i.ready;
  assign out_acc      = item_o.valid && item_o.ready;
  assign b            = byte_i.file_byte;
  assign byte_i.ready = (count_q <= rwp_pkg::QCntW'(rwp_pkg::QDepth - 2));
  assign cfg_i.ready  = 1'b1;

  assign take_pcm16   = (stream_format_q == rwp_pkg::FormatPcm) &&
                        (stream_bits_q == rwp_pkg::BitsPcm);
  assign take_float32 = (stream_format_q == rwp_pkg::FormatFlt) &&
                        (stream_bits_q == rwp_pkg::BitsFlt);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wanted_rate_q <= rwp_pkg::RateReset;
    end else if (cfg_i.valid && cfg_i.ready) begin
      wanted_rate_q <= cfg_i.wanted_rate;
    end
  end

  always_comb begin
    header_count_d      = header_count_q;
    header_good_d       = header_good_q;
    chunk_head_count_d  = chunk_head_count_q;
    chunk_tag_d         = chunk_tag_q;
    chunk_length_d      = chunk_length_q;
    body_left_d         = body_left_q;
    body_offset_d       = body_offset_q;
    chunk_kind_d        = chunk_kind_q;
    pad_pending_d       = pad_pending_q;
    stream_format_d     = stream_format_q;
    stream_channels_d   = stream_channels_q;
    stream_rate_d       = stream_rate_q;
    stream_bits_d       = stream_bits_q;
    data_seen_d         = data_seen_q;
    sample_gather_d     = sample_gather_q;
    sample_byte_count_d = sample_byte_count_q;
    fmt_valid_d         = fmt_valid_q;

    sample_emit = 1'b0;
    sample_item = '0;
    status_item = '0;
    status_item.item_kind = rwp_pkg::ItemStatus;
    status_item.is_last   = 1'b1;
    need        = take_pcm16 ? 3'd2 : (take_float32 ? 3'd4 : 3'd0);
    cnt_inc     = {1'b0, sample_byte_count_q} + 3'd1;
    gather_new  = set_byte(sample_gather_q, sample_byte_count_q, b);
    end_pcm16   = 1'b0;
    end_float32 = 1'b0;

    if (in_acc) begin
      if (header_count_q < rwp_pkg::HeaderLen) begin
        if ((header_count_q < 4'd4 || header_count_q >= 4'd8) &&
            b != rwp_pkg::head_byte(header_count_q)) begin
          header_good_d = 1'b0;
        end
        header_count_d = header_count_q + 4'd1;
      end else if (!header_good_q) begin
        // drop bytes until end of file
        header_good_d = 1'b0;
      end else if (chunk_kind_q == rwp_pkg::ChunkHead) begin
        if (pad_pending_q) begin
          pad_pending_d = 1'b0;
        end else begin
          if (!chunk_head_count_q[2]) begin
            chunk_tag_d = (chunk_head_count_q == 3'd0) ? {24'd0, b}
                        : set_byte(chunk_tag_q, chunk_head_count_q[1:0], b);
          end else begin
            chunk_length_d = (chunk_head_count_q == 3'd4) ? {24'd0, b}
                           : set_byte(chunk_length_q, chunk_head_count_q[1:0], b);
          end
          chunk_head_count_d = chunk_head_count_q + 3'd1;
          if (chunk_head_count_q == 3'd7) begin
            body_left_d         = chunk_length_d;
            body_offset_d       = '0;
            sample_gather_d     = '0;
            sample_byte_count_d = '0;
            if (chunk_tag_q == rwp_pkg::TagFmt) begin
              chunk_kind_d = (chunk_length_d >= rwp_pkg::FmtMinLen) ? rwp_pkg::ChunkFmt
                                                                     : rwp_pkg::ChunkSkip;
            end else if (chunk_tag_q == rwp_pkg::TagData && fmt_valid_q) begin
              chunk_kind_d = rwp_pkg::ChunkData;
              data_seen_d  = 1'b1;
            end else begin
              chunk_kind_d = rwp_pkg::ChunkSkip;
            end
            if (chunk_length_d == 32'd0) chunk_kind_d = rwp_pkg::ChunkHead;
          end
        end
      end else begin
        body_left_d = body_left_q - 32'd1;
        if (chunk_kind_q == rwp_pkg::ChunkFmt) begin
          if (body_offset_q < rwp_pkg::FmtLen) begin
            if (body_offset_q < 5'd2) begin
              stream_format_d = body_offset_q[0] ? {b, stream_format_q[7:0]}
                                                 : {stream_format_q[15:8], b};
            end else if (body_offset_q < 5'd4) begin
              stream_channels_d = body_offset_q[0] ? {b, stream_channels_q[7:0]}
                                                   : {stream_channels_q[15:8], b};
            end else if (body_offset_q < 5'd8) begin
              stream_rate_d = set_byte(stream_rate_q, body_offset_q[1:0], b);
            end else if (body_offset_q == 5'd14 || body_offset_q == 5'd15) begin
              stream_bits_d = body_offset_q[0] ? {b, stream_bits_q[7:0]}
                                               : {stream_bits_q[15:8], b};
            end
            if (body_offset_q == 5'd15) fmt_valid_d = 1'b1;
            body_offset_d = body_offset_q + 5'd1;
          end
        end else if (chunk_kind_q == rwp_pkg::ChunkData && need != 3'd0) begin
          if (cnt_inc == need) begin
            sample_emit = 1'b1;
            if (take_pcm16) begin
              sample_item.item_kind   = rwp_pkg::ItemPcm16;
              sample_item.sample_word = {{16{gather_new[15]}}, gather_new[15:0]};
            end else begin
              sample_item.item_kind   = rwp_pkg::ItemFloat32;
              sample_item.sample_word = gather_new;
            end
            sample_gather_d     = '0;
            sample_byte_count_d = '0;
          end else begin
            sample_gather_d     = gather_new;
            sample_byte_count_d = cnt_inc[1:0];
          end
        end
        if (body_left_d == 32'd0) begin
          pad_pending_d = chunk_length_q[0];
          chunk_kind_d  = rwp_pkg::ChunkHead;
        end
      end

      if (byte_i.end_of_file) begin
        end_pcm16   = (stream_format_d == rwp_pkg::FormatPcm) &&
                      (stream_bits_d == rwp_pkg::BitsPcm);
        end_float32 = (stream_format_d == rwp_pkg::FormatFlt) &&
                      (stream_bits_d == rwp_pkg::BitsFlt);
        priority if (header_count_d < rwp_pkg::HeaderLen || !header_good_d) begin
          status_item.status_code = rwp_pkg::StatusNotRiff;
        end else if (!data_seen_d) begin
          status_item.status_code = rwp_pkg::StatusNoData;
        end else if (stream_channels_d != 16'd1) begin
          status_item.status_code = rwp_pkg::StatusNotMono;
        end else if (!end_pcm16 && !end_float32) begin
          status_item.status_code = rwp_pkg::StatusBadFormat;
        end else if (stream_rate_d != wanted_rate_q) begin
          status_item.status_code = rwp_pkg::StatusWrongRate;
        end else begin
          status_item.status_code = rwp_pkg::StatusOk;
        end
        // start the next file from a clean state
        header_count_d      = '0;
        header_good_d       = 1'b1;
        chunk_head_count_d  = '0;
        chunk_tag_d         = '0;
        chunk_length_d      = '0;
        body_left_d         = '0;
        body_offset_d       = '0;
        chunk_kind_d        = rwp_pkg::ChunkHead;
        pad_pending_d       = 1'b0;
        stream_format_d     = '0;
        stream_channels_d   = '0;
        stream_rate_d       = '0;
        stream_bits_d       = '0;
        data_seen_d         = 1'b0;
        sample_gather_d     = '0;
        sample_byte_count_d = '0;
        fmt_valid_d         = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_count_q      <= '0;
      header_good_q       <= 1'b1;
      chunk_head_count_q  <= '0;
      chunk_tag_q         <= '0;
      chunk_length_q      <= '0;
      body_left_q         <= '0;
      body_offset_q       <= '0;
      chunk_kind_q        <= rwp_pkg::ChunkHead;
      pad_pending_q       <= 1'b0;
      stream_format_q     <= '0;
      stream_channels_q   <= '0;
      stream_rate_q       <= '0;
      stream_bits_q       <= '0;
      data_seen_q         <= 1'b0;
      sample_gather_q     <= '0;
      sample_byte_count_q <= '0;
      fmt_valid_q         <= 1'b0;
    end else begin
      header_count_q      <= header_count_d;
      header_good_q       <= header_good_d;
      chunk_head_count_q  <= chunk_head_count_d;
      chunk_tag_q         <= chunk_tag_d;
      chunk_length_q      <= chunk_length_d;
      body_left_q         <= body_left_d;
      body_offset_q       <= body_offset_d;
      chunk_kind_q        <= chunk_kind_d;
      pad_pending_q       <= pad_pending_d;
      stream_format_q     <= stream_format_d;
      stream_channels_q   <= stream_channels_d;
      stream_rate_q       <= stream_rate_d;
      stream_bits_q       <= stream_bits_d;
      data_seen_q         <= data_seen_d;
      sample_gather_q     <= sample_gather_d;
      sample_byte_count_q <= sample_byte_count_d;
      fmt_valid_q         <= fmt_valid_d;
    end
  end

  // Result queue: up to two pushes and one pop per cycle
  assign n_push     = in_acc ? ({1'b0, sample_emit} + {1'b0, byte_i.end_of_file}) : 2'd0;
  assign first_item = sample_emit ? sample_item : status_item;
  assign count_d    = count_q + rwp_pkg::QCntW'(n_push) - rwp_pkg::QCntW'(out_acc);

  always_ff @(posedge clk_i) begin
    if (n_push != 2'd0) queue_q[wr_ptr_q] <= first_item;
    if (n_push == 2'd2) queue_q[wr_ptr_q + rwp_pkg::QPtrW'(1)] <= status_item;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + rwp_pkg::QPtrW'(n_push);
      rd_ptr_q <= rd_ptr_q + rwp_pkg::QPtrW'(out_acc);
      count_q  <= count_d;
    end
  end

  assign item_o.valid       = (count_q != '0);
  assign item_o.item_kind   = queue_q[rd_ptr_q].item_kind;
  assign item_o.sample_word = queue_q[rd_ptr_q].sample_word;
  assign item_o.status_code = queue_q[rd_ptr_q].status_code;
  assign item_o.is_last     = queue_q[rd_ptr_q].is_last;

  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= rwp_pkg::QCntW'(rwp_pkg::QDepth))
    else $error("result queue over capacity");

  a_eof_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && byte_i.end_of_file |=> header_count_q == '0 && chunk_kind_q == rwp_pkg::ChunkHead
      && !fmt_valid_q && !data_seen_q)
    else $error("parse state not cleared after end of file");

  a_body_after_header: assert property (@(posedge clk_i) disable iff (!rst_ni)
    chunk_kind_q != rwp_pkg::ChunkHead |-> header_good_q && header_count_q == rwp_pkg::HeaderLen
      && body_left_q != 32'd0)
    else $error("chunk body entered without a good header");

  a_pcm_gather: assert property (@(posedge clk_i) disable iff (!rst_ni)
    chunk_kind_q == rwp_pkg::ChunkData && take_pcm16 |-> sample_byte_count_q < 2'd2)
    else $error("pcm16 gather ran past two bytes");

  a_fmt_offset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    body_offset_q <= rwp_pkg::FmtLen && (fmt_valid_q || chunk_kind_q != rwp_pkg::ChunkData))
    else $error("fmt offset or data chunk without fmt");

endmodule

`default_nettype wire
